// ----- src/kfd_pkg.sv -----
// ----------------------------------------------------------------------------
// kfd_pkg
// Shared constants and types for the KISS frame deframer.
// ----------------------------------------------------------------------------
package kfd_pkg;

	// KISS framing characters
	localparam logic [7:0] FEND  = 8'hC0;
	localparam logic [7:0] FESC  = 8'hDB;
	localparam logic [7:0] TFEND = 8'hDC;
	localparam logic [7:0] TFESC = 8'hDD;

	// shortest frame that carries a message, and bytes ahead of the payload
	localparam int unsigned MIN_FRAME    = 6;
	localparam int unsigned HEADER_BYTES = 4;

	// one word of the outgoing message
	typedef struct packed {
		logic       last;
		logic [7:0] body_byte;
		logic [7:0] msg_id;
	} out_word_t;

endpackage

// ----- src/kiss_frame_deframer_top.sv -----
// ----------------------------------------------------------------------------
// kiss_frame_deframer_top
// KISS deframer: serial bytes in, de-escaped message body words out.
// ----------------------------------------------------------------------------
// Input: one received byte per s_axis word. The block hunts for FEND, strips
// FESC escapes and keeps up to FRAME_BYTES bytes in a synchronous frame
// store; further bytes of the frame are dropped. A closing FEND on a frame of
// six or more bytes starts the message: type, length (bytes minus four), then
// frame bytes four onward, each m_axis word tagged with the message id and
// tlast on the final one. Shorter frames are discarded; an empty frame keeps
// the block receiving.
// Throughput: one input byte per cycle while a frame is collected. After a
// closing FEND the id and type bytes are read and the type word registered;
// the rest follow one per cycle while m_axis_tready is high, bounded by the
// single store read port; s_axis_tready is low from the cycle after that FEND
// until the last word is loaded into the output register.
// Stalls: m_axis_tready low holds the output word and the emitter, which in
// turn holds s_axis_tready low if a message is in progress.
// Reset: framing returns to hunting with no escape pending and no output
// word; the frame store is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
module kiss_frame_deframer_top #(
	parameter int unsigned FRAME_BYTES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // [7:0] msg_id, [15:8] body_byte
	output logic        m_axis_tlast
);

	localparam int unsigned AW = $clog2(FRAME_BYTES);
	localparam int unsigned CW = $clog2(FRAME_BYTES + 1);

	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [7:0]         wr_data;
	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic [7:0]         rd_data;
	logic               emit_start;
	logic [CW-1:0]      start_fill;
	logic               emit_busy;
	kfd_pkg::out_word_t out_word;

	// framing and escape removal
	kfd_rx #(
		.FRAME_BYTES(FRAME_BYTES),
		.AW         (AW),
		.CW         (CW)
	) u_rx (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_byte   (s_axis_tdata),
		.emit_busy (emit_busy),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.start     (emit_start),
		.start_fill(start_fill)
	);

	// frame store
	kfd_store #(
		.DEPTH(FRAME_BYTES),
		.AW   (AW)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// message emitter
	kfd_emit #(
		.AW         (AW),
		.CW         (CW)
	) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (emit_start),
		.start_fill(start_fill),
		.busy      (emit_busy),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_word  (out_word)
	);

	assign m_axis_tdata = {out_word.body_byte, out_word.msg_id};
	assign m_axis_tlast = out_word.last;

	// store is never written while the emitter reads it
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && rd_en))
		else $error("frame store written during message read-out");

	// emitter is only started when idle
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		emit_start |-> !emit_busy)
		else $error("emitter started while busy");

	// a started frame length is within bounds
	a_start_len: assert property (@(posedge clk) disable iff (!arst_n)
		emit_start |-> (start_fill >= CW'(kfd_pkg::MIN_FRAME)
			&& start_fill <= CW'(FRAME_BYTES)))
		else $error("frame length out of range at message start");

	// a start is followed by the emitter going busy
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		emit_start |=> emit_busy)
		else $error("emitter did not take the frame");

endmodule

// ----- src/kfd_store.sv -----
// ----------------------------------------------------------------------------
// kfd_store
// Frame store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module kfd_store #(
	parameter int unsigned DEPTH = 32,
	parameter int unsigned AW    = 5
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);

	logic [7:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, data holds until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- src/kfd_rx.sv -----
// ----------------------------------------------------------------------------
// kfd_rx
// Receive side: hunts for FEND, removes escapes, writes the frame store and
// starts the emitter on a closing FEND of a long enough frame.
// ----------------------------------------------------------------------------
module kfd_rx #(
	parameter int unsigned FRAME_BYTES = 32,
	parameter int unsigned AW          = 5,
	parameter int unsigned CW          = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    in_byte,
	input  logic          emit_busy,
	output logic          wr_en,
	output logic [AW-1:0] wr_addr,
	output logic [7:0]    wr_data,
	output logic          start,
	output logic [CW-1:0] start_fill
);

	logic          receiving_q;
	logic          esc_q;
	logic [CW-1:0] fill_q;
	logic          acc;
	logic          is_fend;
	logic          is_fesc;
	logic          room;
	logic [7:0]    data_byte;

	assign in_ready = !emit_busy;
	assign acc      = in_valid && in_ready;
	assign is_fend  = (in_byte == kfd_pkg::FEND);
	assign is_fesc  = (in_byte == kfd_pkg::FESC);
	assign room     = (fill_q != CW'(FRAME_BYTES));

	// translate an escaped byte, pass unknown escapes through raw
	always_comb begin
		data_byte = in_byte;
		if (esc_q && in_byte == kfd_pkg::TFEND) begin
			data_byte = kfd_pkg::FEND;
		end else if (esc_q && in_byte == kfd_pkg::TFESC) begin
			data_byte = kfd_pkg::FESC;
		end
	end

	// store a data byte while there is room, drop it otherwise
	assign wr_en   = acc && receiving_q && !is_fend && !is_fesc && room;
	assign wr_addr = fill_q[AW-1:0];
	assign wr_data = data_byte;

	// hand a complete frame to the emitter
	assign start      = acc && receiving_q && is_fend && (fill_q >= CW'(kfd_pkg::MIN_FRAME));
	assign start_fill = fill_q;

	// framing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			receiving_q <= 1'b0;
			esc_q       <= 1'b0;
			fill_q      <= '0;
		end else if (acc) begin
			if (!receiving_q) begin
				if (is_fend) begin
					receiving_q <= 1'b1;
					fill_q      <= '0;
				end
			end else if (is_fend) begin
				// empty frame keeps receiving; anything else ends the frame
				if (fill_q != '0) begin
					receiving_q <= 1'b0;
				end
			end else if (is_fesc) begin
				esc_q <= 1'b1;
			end else begin
				esc_q <= 1'b0;
				if (room) begin
					fill_q <= fill_q + CW'(1);
				end
			end
		end
	end

endmodule

// ----- src/kfd_emit.sv -----
// ----------------------------------------------------------------------------
// kfd_emit
// Message emitter: reads the frame store and sends type, length and the
// payload bytes through a one-word output register.
// ----------------------------------------------------------------------------
module kfd_emit #(
	parameter int unsigned AW          = 5,
	parameter int unsigned CW          = 6
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [CW-1:0]      start_fill,
	output logic               busy,
	output logic               rd_en,
	output logic [AW-1:0]      rd_addr,
	input  logic [7:0]         rd_data,
	output logic               out_valid,
	input  logic               out_ready,
	output kfd_pkg::out_word_t out_word
);

	typedef enum logic [4:0] {
		E_IDLE = 5'b00001,
		E_ID   = 5'b00010,
		E_TYPE = 5'b00100,
		E_LEN  = 5'b01000,
		E_DATA = 5'b10000
	} emit_state_t;

	emit_state_t        state_q, state_d;
	logic [CW-1:0]      fill_q;
	logic [CW-1:0]      idx_q;
	logic [CW-1:0]      idx_nxt;
	logic [7:0]         id_q;
	logic               out_valid_q;
	kfd_pkg::out_word_t out_q;
	logic               out_free;
	logic               load;
	kfd_pkg::out_word_t load_word;
	logic               data_last;

	assign out_free  = !out_valid_q || out_ready;
	assign idx_nxt   = idx_q + CW'(1);
	assign data_last = (idx_nxt == fill_q);
	assign busy      = (state_q != E_IDLE);
	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	// sequence the store reads and the output loads
	always_comb begin
		state_d   = state_q;
		rd_en     = 1'b0;
		rd_addr   = '0;
		load      = 1'b0;
		load_word = '{last: 1'b0, body_byte: rd_data, msg_id: id_q};
		unique case (state_q)
			E_IDLE: begin
				if (start) begin
					rd_en   = 1'b1;
					rd_addr = AW'(1);
					state_d = E_ID;
				end
			end
			E_ID: begin
				rd_en   = 1'b1;
				rd_addr = '0;
				state_d = E_TYPE;
			end
			E_TYPE: begin
				// a frame of at least six bytes never ends on the type word
				if (out_free) begin
					load    = 1'b1;
					state_d = E_LEN;
				end
			end
			E_LEN: begin
				load_word.body_byte = 8'(fill_q - CW'(kfd_pkg::HEADER_BYTES));
				if (out_free) begin
					load    = 1'b1;
					rd_en   = 1'b1;
					rd_addr = AW'(kfd_pkg::HEADER_BYTES);
					state_d = E_DATA;
				end
			end
			E_DATA: begin
				load_word.last = data_last;
				if (out_free) begin
					load = 1'b1;
					if (data_last) begin
						state_d = E_IDLE;
					end else begin
						rd_en   = 1'b1;
						rd_addr = idx_nxt[AW-1:0];
					end
				end
			end
			default: state_d = E_IDLE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= E_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// frame length, message id, read index and output word
	always_ff @(posedge clk) begin
		if (state_q == E_IDLE && start) begin
			fill_q <= start_fill;
		end
		if (state_q == E_ID) begin
			id_q <= rd_data;
		end
		if (state_q == E_LEN && out_free) begin
			idx_q <= CW'(kfd_pkg::HEADER_BYTES);
		end else if (state_q == E_DATA && out_free) begin
			idx_q <= idx_nxt;
		end
		if (load) begin
			out_q <= load_word;
		end
	end

endmodule
